@@ hw/rtl/rotary_encoder_frame_decoder_unit_assert.svh @@
// assertion macros for the frame decoder checker
// clk and rst are taken from the scope that uses the macro
`ifndef ROTARY_ENCODER_FRAME_DECODER_UNIT_ASSERT_SVH
`define ROTARY_ENCODER_FRAME_DECODER_UNIT_ASSERT_SVH

// antecedent holds, consequent must hold in the same cycle
`define REDU_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("redu check failed");

// antecedent holds, consequent must hold in the next cycle
`define REDU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("redu check failed");

`endif

@@ hw/rtl/redu_pkg.sv @@
package redu_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned POS_W   = 3;
  localparam int unsigned EV_W    = 2;
  localparam int unsigned FRAME_W = 2;
  localparam int unsigned CNT_W   = 2;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned DATA_W  = 3;

  localparam logic [EV_W-1:0] EV_NONE   = 2'd0;
  localparam logic [EV_W-1:0] EV_UP     = 2'd1;
  localparam logic [EV_W-1:0] EV_DOWN   = 2'd2;
  localparam logic [EV_W-1:0] EV_BUTTON = 2'd3;

  localparam logic [IDX_W-1:0] CFG_BUTTON_BIT = 3'd0;
  localparam logic [IDX_W-1:0] CFG_PLUS_BIT   = 3'd1;
  localparam logic [IDX_W-1:0] CFG_MINUS_BIT  = 3'd2;
  localparam logic [IDX_W-1:0] CFG_INVERT     = 3'd3;

  localparam logic [POS_W-1:0] BUTTON_BIT_RST = 3'd0;
  localparam logic [POS_W-1:0] PLUS_BIT_RST   = 3'd1;
  localparam logic [POS_W-1:0] MINUS_BIT_RST  = 3'd2;

  // last frame slot of a capture, count value at which decoding happens
  localparam logic [CNT_W-1:0] LAST_FRAME = 2'd2;

  typedef struct packed {
    logic btn;
    logic plus;
    logic minus;
  } lines_t;

endpackage

@@ hw/rtl/redu_line_pick.sv @@
module redu_line_pick (
  input  logic [redu_pkg::BYTE_W-1:0] port_byte,
  input  logic [redu_pkg::POS_W-1:0]  button_bit,
  input  logic [redu_pkg::POS_W-1:0]  plus_bit,
  input  logic [redu_pkg::POS_W-1:0]  minus_bit,
  output redu_pkg::lines_t            lines
);

  // raw pin levels, each line read at its own position even if shared
  always_comb begin
    lines.btn   = port_byte[button_bit];
    lines.plus  = port_byte[plus_bit];
    lines.minus = port_byte[minus_bit];
  end

endmodule

@@ hw/rtl/redu_frame_capture.sv @@
module redu_frame_capture (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  redu_pkg::lines_t          lines,
  input  logic                      invert_direction,
  output logic [redu_pkg::EV_W-1:0] ev
);

  logic [redu_pkg::FRAME_W-1:0] frame0, frame0_next;
  logic [redu_pkg::FRAME_W-1:0] frame1, frame1_next;
  logic [redu_pkg::CNT_W-1:0]   frame_count, frame_count_next;
  logic                         capture_active, capture_active_next;

  logic [redu_pkg::FRAME_W-1:0] cur;
  logic [redu_pkg::CNT_W-1:0]   idx;

  function automatic logic [redu_pkg::EV_W-1:0] decode_dir(
    input logic [redu_pkg::FRAME_W-1:0] f0,
    input logic [redu_pkg::FRAME_W-1:0] f1,
    input logic [redu_pkg::FRAME_W-1:0] f2,
    input logic                         inv
  );
    logic [redu_pkg::EV_W-1:0] dir;
    dir = redu_pkg::EV_NONE;
    if (f0[1] && !f0[0]) begin
      dir = redu_pkg::EV_UP;
    end else if (f0[0] && !f0[1]) begin
      dir = redu_pkg::EV_DOWN;
    end
    if (f1 != '0) begin
      dir = redu_pkg::EV_NONE;
    end
    // only a repeat of the first frame's pattern in the third frame cancels
    if ((dir == redu_pkg::EV_UP && f2[1] && !f2[0]) ||
        (dir == redu_pkg::EV_DOWN && !f2[1] && f2[0])) begin
      dir = redu_pkg::EV_NONE;
    end
    if (inv) begin
      if (dir == redu_pkg::EV_UP) begin
        dir = redu_pkg::EV_DOWN;
      end else if (dir == redu_pkg::EV_DOWN) begin
        dir = redu_pkg::EV_UP;
      end
    end
    return dir;
  endfunction

  always_comb begin
    cur = {lines.plus, lines.minus};
    idx = (frame_count > redu_pkg::LAST_FRAME) ? redu_pkg::LAST_FRAME : frame_count;
    frame0_next         = frame0;
    frame1_next         = frame1;
    frame_count_next    = frame_count;
    capture_active_next = capture_active;
    ev                  = redu_pkg::EV_NONE;
    if (!lines.btn) begin
      // button sample leaves the capture untouched
      ev = redu_pkg::EV_BUTTON;
    end else if (capture_active || !lines.plus || !lines.minus) begin
      case (idx)
        2'd0:    frame0_next = cur;
        2'd1:    frame1_next = cur;
        default: frame1_next = frame1;
      endcase
      if (idx == redu_pkg::LAST_FRAME) begin
        capture_active_next = 1'b0;
        frame_count_next    = '0;
        ev = decode_dir(frame0, frame1, cur, invert_direction);
      end else begin
        capture_active_next = 1'b1;
        frame_count_next    = idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame0         <= '0;
      frame1         <= '0;
      frame_count    <= '0;
      capture_active <= 1'b0;
    end else if (step) begin
      frame0         <= frame0_next;
      frame1         <= frame1_next;
      frame_count    <= frame_count_next;
      capture_active <= capture_active_next;
    end
  end

endmodule

@@ hw/rtl/rotary_encoder_frame_decoder_unit.sv @@
// Rotary encoder frame decoder: takes one sampled port byte per transfer and
// returns one event per byte (none, up, down or button). A byte is held in the
// input register, is decoded combinationally against the capture state, and
// its event is registered in the output register; the block sustains one byte
// per clock while the output is not stalled, since the capture state is updated
// as each byte advances. Output backpressure holds the input stage.
// The user writes bit positions and the direction swap through the cfg port
// only while no byte is in flight; the block itself does not enforce this.
module rotary_encoder_frame_decoder_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [redu_pkg::BYTE_W-1:0]   port_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [redu_pkg::EV_W-1:0]     event_res,
  input  logic                          cfg_we,
  input  logic [redu_pkg::IDX_W-1:0]    cfg_index,
  input  logic [redu_pkg::DATA_W-1:0]   cfg_wdata
);

  logic [redu_pkg::POS_W-1:0]  button_bit;
  logic [redu_pkg::POS_W-1:0]  plus_bit;
  logic [redu_pkg::POS_W-1:0]  minus_bit;
  logic                        invert_direction;

  logic                        s1_valid;
  logic [redu_pkg::BYTE_W-1:0] s1_byte;
  logic                        advance;
  redu_pkg::lines_t            lines;
  logic [redu_pkg::EV_W-1:0]   ev;

  always_ff @(posedge clk) begin
    if (rst) begin
      button_bit       <= redu_pkg::BUTTON_BIT_RST;
      plus_bit         <= redu_pkg::PLUS_BIT_RST;
      minus_bit        <= redu_pkg::MINUS_BIT_RST;
      invert_direction <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        redu_pkg::CFG_BUTTON_BIT: button_bit       <= cfg_wdata[redu_pkg::POS_W-1:0];
        redu_pkg::CFG_PLUS_BIT:   plus_bit         <= cfg_wdata[redu_pkg::POS_W-1:0];
        redu_pkg::CFG_MINUS_BIT:  minus_bit        <= cfg_wdata[redu_pkg::POS_W-1:0];
        redu_pkg::CFG_INVERT:     invert_direction <= cfg_wdata[0];
        default:                  invert_direction <= invert_direction;
      endcase
    end
  end

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= port_byte;
    end
  end

  redu_line_pick u_line_pick (
    .port_byte  (s1_byte),
    .button_bit (button_bit),
    .plus_bit   (plus_bit),
    .minus_bit  (minus_bit),
    .lines      (lines)
  );

  redu_frame_capture u_frame_capture (
    .clk              (clk),
    .rst              (rst),
    .step             (advance),
    .lines            (lines),
    .invert_direction (invert_direction),
    .ev               (ev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      event_res <= ev;
    end
  end

endmodule

@@ hw/rtl/redu_checker.sv @@
`include "rotary_encoder_frame_decoder_unit_assert.svh"

module redu_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [redu_pkg::EV_W-1:0]   event_res
);

  logic       in_xfer;
  logic       out_xfer;
  logic [1:0] occupancy;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // bytes taken whose events are not yet transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else if (in_xfer && !out_xfer) begin
      occupancy <= occupancy + 2'd1;
    end else if (out_xfer && !in_xfer) begin
      occupancy <= occupancy - 2'd1;
    end
  end

  `REDU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(event_res))
  `REDU_ASSERT_SAME(a_occ_bound, 1'b1, occupancy <= 2'd2)
  `REDU_ASSERT_SAME(a_no_invent, out_valid, occupancy != 2'd0)
  `REDU_ASSERT_SAME(a_stall_cause, !in_ready, out_valid && !out_ready)

endmodule

bind rotary_encoder_frame_decoder_unit redu_checker u_redu_checker (.*);

@@ bench/rotary_encoder_frame_decoder_unit_test.sv @@
`timescale 1ns / 1ps

module rotary_encoder_frame_decoder_unit_test;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [redu_pkg::BYTE_W-1:0]     port_byte = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [redu_pkg::EV_W-1:0]       event_res;
  logic                            cfg_we = 1'b0;
  logic [redu_pkg::IDX_W-1:0]      cfg_index = '0;
  logic [redu_pkg::DATA_W-1:0]     cfg_wdata = '0;

  rotary_encoder_frame_decoder_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .port_byte (port_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .event_res (event_res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // decoder state as predicted by the bench
  logic [redu_pkg::POS_W-1:0]   btn_pos   = redu_pkg::BUTTON_BIT_RST;
  logic [redu_pkg::POS_W-1:0]   plus_pos  = redu_pkg::PLUS_BIT_RST;
  logic [redu_pkg::POS_W-1:0]   minus_pos = redu_pkg::MINUS_BIT_RST;
  logic                         swap_dir  = 1'b0;
  logic [redu_pkg::FRAME_W-1:0] frames [3] = '{default: '0};
  logic [redu_pkg::CNT_W-1:0]   frame_cnt = '0;
  logic                         capturing = 1'b0;

  logic [redu_pkg::EV_W-1:0] expected_events [$];
  logic            idle_on = 1'b1;
  int              errors = 0;
  int              bytes_sent = 0;
  int              settings_used = 1;
  int              ups_seen = 0;
  int              downs_seen = 0;
  int              buttons_seen = 0;
  int              out_hold = 0;
  int              out_stall;

  task automatic report(input string msg);
    errors++;
    if (errors <= 50) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  function automatic logic [redu_pkg::EV_W-1:0] predict_event(
    input logic [redu_pkg::BYTE_W-1:0] b
  );
    logic                         p;
    logic                         m;
    logic [redu_pkg::CNT_W-1:0]   slot;
    logic [redu_pkg::EV_W-1:0]    dir;
    logic [redu_pkg::FRAME_W-1:0] f0;
    logic [redu_pkg::FRAME_W-1:0] f1;
    logic [redu_pkg::FRAME_W-1:0] f2;
    p = b[plus_pos];
    m = b[minus_pos];
    dir = redu_pkg::EV_NONE;
    // a pressed button masks the sample, capture left as it was
    if (!b[btn_pos]) return redu_pkg::EV_BUTTON;
    if (!capturing && (!p || !m)) capturing = 1'b1;
    if (capturing) begin
      slot = (frame_cnt > redu_pkg::LAST_FRAME) ? redu_pkg::LAST_FRAME : frame_cnt;
      frames[slot] = {p, m};
      if (slot == redu_pkg::LAST_FRAME) begin
        capturing = 1'b0;
        frame_cnt = '0;
        f0 = frames[0];
        f1 = frames[1];
        f2 = frames[2];
        if (f0 == 2'b10) dir = redu_pkg::EV_UP;
        else if (f0 == 2'b01) dir = redu_pkg::EV_DOWN;
        if (f1 != 2'b00) dir = redu_pkg::EV_NONE;
        // only a repeat of the first frame's pattern in the last frame cancels
        if ((dir == redu_pkg::EV_UP && f2 == 2'b10) ||
            (dir == redu_pkg::EV_DOWN && f2 == 2'b01))
          dir = redu_pkg::EV_NONE;
        if (swap_dir && dir == redu_pkg::EV_UP) dir = redu_pkg::EV_DOWN;
        else if (swap_dir && dir == redu_pkg::EV_DOWN) dir = redu_pkg::EV_UP;
      end else begin
        frame_cnt = slot + 1'b1;
      end
    end
    return dir;
  endfunction

  // byte with the given line levels at the configured bits, noise elsewhere
  function automatic logic [redu_pkg::BYTE_W-1:0] make_byte(input logic btn,
                                                           input logic [1:0] pm);
    logic [redu_pkg::BYTE_W-1:0] b;
    b = 8'($urandom);
    b[plus_pos] = pm[1];
    b[minus_pos] = pm[0];
    b[btn_pos] = btn;
    return b;
  endfunction

  task automatic send_byte(input logic [redu_pkg::BYTE_W-1:0] b);
    int gap;
    gap = idle_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    port_byte <= b;
    do @(posedge clk); while (!in_ready);
    expected_events.push_back(predict_event(b));
    bytes_sent++;
  endtask

  task automatic send_frames(input logic [1:0] f0, input logic [1:0] f1, input logic [1:0] f2);
    send_byte(make_byte(1'b1, f0));
    send_byte(make_byte(1'b1, f1));
    send_byte(make_byte(1'b1, f2));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input logic [redu_pkg::IDX_W-1:0] idx,
                         input logic [redu_pkg::DATA_W-1:0] data);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      redu_pkg::CFG_BUTTON_BIT: btn_pos = data;
      redu_pkg::CFG_PLUS_BIT:   plus_pos = data;
      redu_pkg::CFG_MINUS_BIT:  minus_pos = data;
      redu_pkg::CFG_INVERT:     swap_dir = data[0];
      default: ;
    endcase
  endtask

  task automatic set_all(input logic [redu_pkg::POS_W-1:0] b,
                         input logic [redu_pkg::POS_W-1:0] p,
                         input logic [redu_pkg::POS_W-1:0] m,
                         input logic [redu_pkg::DATA_W-1:0] inv);
    set_reg(redu_pkg::CFG_BUTTON_BIT, b);
    set_reg(redu_pkg::CFG_PLUS_BIT, p);
    set_reg(redu_pkg::CFG_MINUS_BIT, m);
    set_reg(redu_pkg::CFG_INVERT, inv);
    settings_used++;
  endtask

  // reset settings: extremes of the byte, every decode outcome, button mid capture
  task automatic test_reset_settings();
    idle_on = 1'b1;
    send_byte(8'hFF);
    send_byte(8'h00);
    send_frames(2'b10, 2'b00, 2'b01);
    send_frames(2'b01, 2'b00, 2'b10);
    send_frames(2'b10, 2'b01, 2'b01);
    send_frames(2'b10, 2'b00, 2'b10);
    idle_on = 1'b0;
    send_frames(2'b01, 2'b00, 2'b01);
    send_frames(2'b00, 2'b00, 2'b11);
    send_byte(make_byte(1'b1, 2'b10));
    send_byte(make_byte(1'b0, 2'b11));
    send_byte(make_byte(1'b1, 2'b00));
    send_byte(make_byte(1'b1, 2'b01));
  endtask

  task automatic test_registers();
    idle_on = 1'b1;
    // upper positions with direction swapped
    set_all(3'd7, 3'd6, 3'd5, 3'd1);
    send_frames(2'b10, 2'b00, 2'b01);
    send_frames(2'b01, 2'b00, 2'b10);
    send_byte(make_byte(1'b0, 2'b11));
    // plus and minus on the same pin
    set_all(3'd0, 3'd7, 3'd7, 3'd0);
    send_frames(2'b00, 2'b00, 2'b11);
    send_frames(2'b11, 2'b00, 2'b00);
    // button shares the plus pin
    set_all(3'd3, 3'd3, 3'd4, 3'd0);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frames(2'b11, 2'b10, 2'b10);
    // only bit 0 of the swap register counts
    set_reg(redu_pkg::CFG_INVERT, 3'b110);
    set_all(3'd0, 3'd1, 3'd2, 3'b110);
    send_frames(2'b10, 2'b00, 2'b01);
    // writes past the last register are dropped
    for (int i = redu_pkg::CFG_INVERT + 1; i < 8; i++) begin
      set_reg(i[redu_pkg::IDX_W-1:0], 3'd7);
      set_reg(i[redu_pkg::IDX_W-1:0], 3'd0);
    end
    send_frames(2'b10, 2'b00, 2'b01);
    send_frames(2'b01, 2'b00, 2'b10);
  endtask

  task automatic test_random_traffic(input int phases, input int per_phase);
    int stop_at;
    int pick;
    logic [1:0] f [3];
    for (int ph = 0; ph < phases; ph++) begin
      if (ph == 0) set_all(3'd0, 3'd0, 3'd7, 3'd0);
      else if (ph == 1) set_all(3'd7, 3'd7, 3'd0, 3'd7);
      else set_all(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                   3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
      set_reg(3'($urandom_range(redu_pkg::CFG_INVERT + 1, 7)), 3'($urandom_range(0, 7)));
      idle_on = (ph % 3) != 2;
      stop_at = bytes_sent + per_phase;
      while (bytes_sent < stop_at) begin
        if ($urandom_range(0, 19) == 0) idle_on = !idle_on;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          repeat ($urandom_range(0, 3)) send_byte(make_byte(1'b1, 2'b11));
          f[0] = $urandom_range(0, 1) ? 2'b10 : 2'b01;
          f[1] = ($urandom_range(0, 5) == 0) ? 2'($urandom) : 2'b00;
          if ($urandom_range(0, 4) == 0) f[2] = 2'($urandom);
          else f[2] = ~f[0];
          for (int k = 0; k < 3; k++) begin
            if ($urandom_range(0, 24) == 0) send_byte(make_byte(1'b0, 2'($urandom)));
            send_byte(make_byte(1'b1, f[k]));
          end
        end else if (pick < 80) begin
          send_byte(make_byte(1'b0, 2'($urandom)));
        end else begin
          send_byte(8'($urandom));
        end
      end
    end
  endtask

  // result side: check each transfer, then stall a random number of cycles while idle gaps are on
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_hold <= 0;
    end else if (out_valid && out_ready) begin
      if (expected_events.size() == 0) begin
        report($sformatf("event %0d with nothing expected", event_res));
      end else if (event_res !== expected_events[0]) begin
        report($sformatf("event %0d, expected %0d", event_res, expected_events[0]));
        void'(expected_events.pop_front());
      end else begin
        void'(expected_events.pop_front());
      end
      case (event_res)
        redu_pkg::EV_UP:     ups_seen++;
        redu_pkg::EV_DOWN:   downs_seen++;
        redu_pkg::EV_BUTTON: buttons_seen++;
        default: ;
      endcase
      out_stall = idle_on ? $urandom_range(0, 14) : 0;
      if (out_stall == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        out_hold <= out_stall;
      end
    end else if (out_hold > 0) begin
      out_hold <= out_hold - 1;
      out_ready <= (out_hold == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_settings();
    test_registers();
    test_random_traffic(8, 205);
    wait_drained();
    repeat (10) @(posedge clk);
    $display("sent %0d port bytes over %0d register settings", bytes_sent, settings_used);
    $display("seen %0d up, %0d down and %0d button events", ups_seen, downs_seen,
             buttons_seen);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d events outstanding", expected_events.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/redu_pkg.sv
hw/rtl/redu_line_pick.sv
hw/rtl/redu_frame_capture.sv
hw/rtl/rotary_encoder_frame_decoder_unit.sv
hw/rtl/redu_checker.sv
bench/rotary_encoder_frame_decoder_unit_test.sv
